/* rtl/g2u_pkg.sv */
// Shared constants, types and helper functions of the GBK to UTF-8 converter.
`default_nettype none
package g2u_pkg;

    // Mapping table geometry.
    localparam int TABLE_DEPTH = 32768;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int BOUND_W     = ADDR_W + 1;

    // Fixed field widths.
    localparam int ENTRY_IDX_W = 15;
    localparam int CODE_W      = 16;
    localparam int REG_W       = 16;
    localparam int CFG_IDX_W   = 1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_ENTRIES_IN_USE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_CAPACITY = 1'b1;

    localparam logic [REG_W-1:0] CAPACITY_RESET = 16'd256;

    // Item commands.
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TEXT = 1'b1;

    // Byte classes and UTF-8 framing.
    localparam logic [7:0]  ASCII_LIMIT  = 8'h80;
    localparam logic [7:0]  LEAD_MIN     = 8'h81;
    localparam logic [7:0]  LEAD_MAX     = 8'hFE;
    localparam logic [7:0]  TRAIL_MIN    = 8'h40;
    localparam logic [7:0]  TERMINATOR   = 8'h00;
    localparam logic [15:0] TWO_BYTE_LIM = 16'h0800;
    localparam logic [7:0]  LEAD2_MARK   = 8'hC0;
    localparam logic [7:0]  LEAD3_MARK   = 8'hE0;
    localparam logic [7:0]  CONT_MARK    = 8'h80;
    localparam logic [5:0]  CONT_MASK    = 6'h3F;

    // Control of the search unit by the sequencer.
    typedef struct packed {
        logic start;
        logic probe;
        logic compare;
    } srch_ctrl_t;

    // Status of the search unit.
    typedef struct packed {
        logic more;
        logic hit;
        logic below;
    } srch_stat_t;

    // Number of UTF-8 bytes for a code point.
    function automatic logic [1:0] utf8_len(input logic [CODE_W-1:0] cp);
        logic [1:0] len;
        if (cp < {8'h00, ASCII_LIMIT})
        begin
            len = 2'd1;
        end
        else if (cp < TWO_BYTE_LIM)
        begin
            len = 2'd2;
        end
        else
        begin
            len = 2'd3;
        end
        return len;
    endfunction

    // Byte k of the UTF-8 form of cp, whose length is len.
    function automatic logic [7:0] utf8_byte(input logic [CODE_W-1:0] cp,
                                             input logic [1:0]        len,
                                             input logic [1:0]        k);
        logic [7:0] b;
        logic [7:0] cont_lo;
        logic [7:0] cont_mid;
        cont_lo  = CONT_MARK | {2'b00, cp[5:0] & CONT_MASK};
        cont_mid = CONT_MARK | {2'b00, cp[11:6] & CONT_MASK};
        if (len == 2'd1)
        begin
            b = cp[7:0];
        end
        else if (len == 2'd2)
        begin
            b = (k == 2'd0) ? (LEAD2_MARK | {3'b000, cp[10:6]}) : cont_lo;
        end
        else
        begin
            if (k == 2'd0)
            begin
                b = LEAD3_MARK | {4'h0, cp[15:12]};
            end
            else if (k == 2'd1)
            begin
                b = cont_mid;
            end
            else
            begin
                b = cont_lo;
            end
        end
        return b;
    endfunction

endpackage
`default_nettype wire

/* rtl/g2u_ifs.sv */
// Channel interfaces of the GBK to UTF-8 converter: items, results and configuration.
`default_nettype none
interface g2u_item_if;
    import g2u_pkg::*;
    logic                   valid;
    logic                   ready;
    logic                   cmd;
    logic [7:0]             text_byte;
    logic [ENTRY_IDX_W-1:0] entry_index;
    logic [CODE_W-1:0]      entry_gbk_code;
    logic [CODE_W-1:0]      entry_unicode;

    modport source (output valid, cmd, text_byte, entry_index, entry_gbk_code,
                    entry_unicode, input ready);
    modport sink   (input valid, cmd, text_byte, entry_index, entry_gbk_code,
                    entry_unicode, output ready);
endinterface

interface g2u_result_if;
    import g2u_pkg::*;
    logic             valid;
    logic             ready;
    logic [7:0]       out_byte;
    logic             is_summary;
    logic [REG_W-1:0] byte_count;
    logic             last;

    modport source (output valid, out_byte, is_summary, byte_count, last, input ready);
    modport sink   (input valid, out_byte, is_summary, byte_count, last, output ready);
endinterface

interface g2u_cfg_if;
    import g2u_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [REG_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* rtl/g2u_table.sv */
// Code and code point table memory: one write port and one registered read port.
`default_nettype none
module g2u_table (
    input  wire logic                      clk,
    input  wire logic                      wr_en,
    input  wire logic [g2u_pkg::ADDR_W-1:0] wr_addr,
    input  wire logic [g2u_pkg::CODE_W-1:0] wr_code,
    input  wire logic [g2u_pkg::CODE_W-1:0] wr_unicode,
    input  wire logic                      rd_en,
    input  wire logic [g2u_pkg::ADDR_W-1:0] rd_addr,
    output logic      [g2u_pkg::CODE_W-1:0] rd_code,
    output logic      [g2u_pkg::CODE_W-1:0] rd_unicode
);
    import g2u_pkg::*;

    logic [2*CODE_W-1:0] mem [TABLE_DEPTH];
    logic [2*CODE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= {wr_code, wr_unicode};
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_code    = rd_data_reg[2*CODE_W-1:CODE_W];
    assign rd_unicode = rd_data_reg[CODE_W-1:0];

endmodule
`default_nettype wire

/* rtl/g2u_search.sv */
// Binary search unit: bounds, midpoint and the equal and less-than key comparators.
`default_nettype none
module g2u_search (
    input  wire logic                       clk,
    input  wire g2u_pkg::srch_ctrl_t        ctrl,
    input  wire logic [g2u_pkg::BOUND_W-1:0] entries,
    input  wire logic [g2u_pkg::CODE_W-1:0]  key,
    input  wire logic [g2u_pkg::CODE_W-1:0]  rd_code,
    output g2u_pkg::srch_stat_t             stat,
    output logic      [g2u_pkg::ADDR_W-1:0]  probe_addr
);
    import g2u_pkg::*;

    // The live window is [lo_reg, hi_reg): hi_reg is one past the upper bound.
    logic [BOUND_W-1:0] lo_reg;
    logic [BOUND_W-1:0] hi_reg;
    logic [ADDR_W-1:0]  mid_reg;
    logic [CODE_W-1:0]  key_reg;
    logic [BOUND_W-1:0] span;
    logic [BOUND_W-1:0] mid_full;

    assign span       = hi_reg - lo_reg - BOUND_W'(1);
    assign mid_full   = lo_reg + (span >> 1);
    assign probe_addr = mid_full[ADDR_W-1:0];

    assign stat.more  = (lo_reg < hi_reg);
    assign stat.hit   = (rd_code == key_reg);
    assign stat.below = (rd_code < key_reg);

    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            lo_reg  <= '0;
            hi_reg  <= entries;
            key_reg <= key;
        end
        else if (ctrl.compare)
        begin
            if (stat.below)
            begin
                lo_reg <= BOUND_W'(mid_reg) + BOUND_W'(1);
            end
            else if (!stat.hit)
            begin
                hi_reg <= BOUND_W'(mid_reg);
            end
        end
        if (ctrl.probe)
        begin
            mid_reg <= probe_addr;
        end
    end

endmodule
`default_nettype wire

/* rtl/gbk_to_utf8_stream_converter.sv */
// Top level of the GBK to UTF-8 converter: sequencer, registers and output stage.
//
// Usage. Items arrive on the item channel. A load item (cmd 0) writes one
// table slot (GBK code and code point) and gives no result. A text item
// (cmd 1) carries one GBK byte; byte 0 ends a string and causes a summary
// result with the string's UTF-8 byte count. Results leave one byte per
// transfer on the result channel, with last marking the final result of
// the item. The configuration channel is always ready and writes the entry
// count and the output capacity; write it only while the block is idle.
// Steps: a load item, a lead byte or an invalid lead is done on transfer; a
// terminator goes on to the summary state, a single-byte character to the
// check state and then, unless output stops, to the emit state. A
// double-byte character runs search probes (table read, then compare),
// up to 16 probes for a full table, then on a hit the check and emit states,
// which emit its UTF-8 bytes one at a time. The item channel is not ready
// while an item is being worked on. A result register decouples the output:
// when the receiver stalls, the block holds its next result in the emit or
// summary state until that register is free. Reset clears the sequencer,
// string state and registers (capacity 256, no entries); the table memory
// keeps its contents and needs no clearing pass.
`default_nettype none
module gbk_to_utf8_stream_converter (
    input  wire logic    clk,
    input  wire logic    rst_n,
    g2u_item_if.sink     item,
    g2u_result_if.source result,
    g2u_cfg_if.sink      cfg
);
    import g2u_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE    = 6'b000001,
        ST_PROBE   = 6'b000010,
        ST_COMPARE = 6'b000100,
        ST_CHECK   = 6'b001000,
        ST_EMIT    = 6'b010000,
        ST_SUMMARY = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers.
    logic [REG_W-1:0] entries_reg;
    logic [REG_W-1:0] capacity_reg;

    // String state.
    logic [7:0]       held_lead_reg, held_lead_next;
    logic             lead_pending_reg, lead_pending_next;
    logic [REG_W-1:0] bytes_used_reg, bytes_used_next;
    logic             stopped_reg, stopped_next;

    // Character being worked on.
    logic [CODE_W-1:0] cp_reg, cp_next;
    logic [1:0]        len_reg, len_next;
    logic [1:0]        emit_idx_reg, emit_idx_next;
    logic [REG_W-1:0]  summary_count_reg, summary_count_next;

    // Result register.
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_byte_reg, out_byte_next;
    logic             out_summary_reg, out_summary_next;
    logic [REG_W-1:0] out_count_reg, out_count_next;
    logic             out_last_reg, out_last_next;

    logic item_fire;
    logic slot_free;

    // Search unit and table connections.
    srch_ctrl_t         srch_ctrl;
    srch_stat_t         srch_stat;
    logic [BOUND_W-1:0] entries_clamped;
    logic [ADDR_W-1:0]  probe_addr;
    logic [CODE_W-1:0]  rd_code;
    logic [CODE_W-1:0]  rd_unicode;
    logic               tbl_wr_en;
    logic               tbl_rd_en;
    logic [CODE_W-1:0]  search_key;

    logic [1:0]     cand_len;
    logic [REG_W:0] need_total;

    assign item.ready = (state_reg == ST_IDLE);
    assign item_fire  = item.valid && item.ready;
    assign cfg.ready  = 1'b1;
    assign slot_free  = !out_valid_reg || result.ready;

    assign result.valid      = out_valid_reg;
    assign result.out_byte   = out_byte_reg;
    assign result.is_summary = out_summary_reg;
    assign result.byte_count = out_count_reg;
    assign result.last       = out_last_reg;

    // The entry count is clamped to the table depth.
    assign entries_clamped = ({1'b0, entries_reg} > (REG_W+1)'(TABLE_DEPTH)) ?
                             BOUND_W'(TABLE_DEPTH) : BOUND_W'(entries_reg);

    assign search_key = {held_lead_reg, item.text_byte};

    assign tbl_wr_en = item_fire && (item.cmd == CMD_LOAD) &&
                       ((ENTRY_IDX_W+1)'(item.entry_index) < (ENTRY_IDX_W+1)'(TABLE_DEPTH));

    assign cand_len   = utf8_len(cp_reg);
    assign need_total = {1'b0, bytes_used_reg} + (REG_W+1)'(cand_len);

    g2u_table u_table (
        .clk        (clk),
        .wr_en      (tbl_wr_en),
        .wr_addr    (ADDR_W'(item.entry_index)),
        .wr_code    (item.entry_gbk_code),
        .wr_unicode (item.entry_unicode),
        .rd_en      (tbl_rd_en),
        .rd_addr    (probe_addr),
        .rd_code    (rd_code),
        .rd_unicode (rd_unicode)
    );

    g2u_search u_search (
        .clk        (clk),
        .ctrl       (srch_ctrl),
        .entries    (entries_clamped),
        .key        (search_key),
        .rd_code    (rd_code),
        .stat       (srch_stat),
        .probe_addr (probe_addr)
    );

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entries_reg  <= '0;
            capacity_reg <= CAPACITY_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                REG_ENTRIES_IN_USE:  entries_reg  <= cfg.data;
                REG_OUTPUT_CAPACITY: capacity_reg <= cfg.data;
                default:             entries_reg  <= entries_reg;
            endcase
        end
    end

    // Sequencer.
    always_comb
    begin
        state_next         = state_reg;
        held_lead_next     = held_lead_reg;
        lead_pending_next  = lead_pending_reg;
        bytes_used_next    = bytes_used_reg;
        stopped_next       = stopped_reg;
        cp_next            = cp_reg;
        len_next           = len_reg;
        emit_idx_next      = emit_idx_reg;
        summary_count_next = summary_count_reg;
        out_valid_next     = out_valid_reg && !result.ready;
        out_byte_next      = out_byte_reg;
        out_summary_next   = out_summary_reg;
        out_count_next     = out_count_reg;
        out_last_next      = out_last_reg;
        srch_ctrl          = '0;
        tbl_rd_en          = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_fire && (item.cmd == CMD_TEXT))
                begin
                    // Any text byte consumes a held lead.
                    held_lead_next    = '0;
                    lead_pending_next = 1'b0;
                    priority if (item.text_byte == TERMINATOR)
                    begin
                        summary_count_next = bytes_used_reg;
                        bytes_used_next    = '0;
                        stopped_next       = 1'b0;
                        state_next         = ST_SUMMARY;
                    end
                    else if (lead_pending_reg && (item.text_byte >= TRAIL_MIN))
                    begin
                        srch_ctrl.start = 1'b1;
                        state_next      = ST_PROBE;
                    end
                    else if (item.text_byte < ASCII_LIMIT)
                    begin
                        cp_next    = {8'h00, item.text_byte};
                        state_next = ST_CHECK;
                    end
                    else if ((item.text_byte >= LEAD_MIN) && (item.text_byte <= LEAD_MAX))
                    begin
                        held_lead_next    = item.text_byte;
                        lead_pending_next = 1'b1;
                    end
                    else
                    begin
                        // Invalid lead byte: skipped.
                        state_next = ST_IDLE;
                    end
                end
            end

            ST_PROBE:
            begin
                if (srch_stat.more)
                begin
                    srch_ctrl.probe = 1'b1;
                    tbl_rd_en       = 1'b1;
                    state_next      = ST_COMPARE;
                end
                else
                begin
                    // Lookup miss: nothing is emitted.
                    state_next = ST_IDLE;
                end
            end

            ST_COMPARE:
            begin
                if (srch_stat.hit)
                begin
                    cp_next    = rd_unicode;
                    state_next = ST_CHECK;
                end
                else
                begin
                    srch_ctrl.compare = 1'b1;
                    state_next        = ST_PROBE;
                end
            end

            ST_CHECK:
            begin
                if ((cp_reg == '0) || stopped_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (need_total >= {1'b0, capacity_reg})
                begin
                    stopped_next = 1'b1;
                    state_next   = ST_IDLE;
                end
                else
                begin
                    bytes_used_next = need_total[REG_W-1:0];
                    len_next        = cand_len;
                    emit_idx_next   = '0;
                    state_next      = ST_EMIT;
                end
            end

            ST_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next   = 1'b1;
                    out_byte_next    = utf8_byte(cp_reg, len_reg, emit_idx_reg);
                    out_summary_next = 1'b0;
                    out_count_next   = '0;
                    out_last_next    = (emit_idx_reg == (len_reg - 2'd1));
                    emit_idx_next    = emit_idx_reg + 2'd1;
                    if (emit_idx_reg == (len_reg - 2'd1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            ST_SUMMARY:
            begin
                if (slot_free)
                begin
                    out_valid_next   = 1'b1;
                    out_byte_next    = '0;
                    out_summary_next = 1'b1;
                    out_count_next   = summary_count_reg;
                    out_last_next    = 1'b1;
                    state_next       = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            held_lead_reg    <= '0;
            lead_pending_reg <= 1'b0;
            bytes_used_reg   <= '0;
            stopped_reg      <= 1'b0;
            out_valid_reg    <= 1'b0;
            emit_idx_reg     <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            held_lead_reg    <= held_lead_next;
            lead_pending_reg <= lead_pending_next;
            bytes_used_reg   <= bytes_used_next;
            stopped_reg      <= stopped_next;
            out_valid_reg    <= out_valid_next;
            emit_idx_reg     <= emit_idx_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        cp_reg            <= cp_next;
        len_reg           <= len_next;
        summary_count_reg <= summary_count_next;
        out_byte_reg      <= out_byte_next;
        out_summary_reg   <= out_summary_next;
        out_count_reg     <= out_count_next;
        out_last_reg      <= out_last_next;
    end

endmodule
`default_nettype wire

/* dv/gbk_to_utf8_stream_converter_tb.sv */
// Self-checking testbench of the GBK to UTF-8 stream converter: directed table, then random strings.
module gbk_to_utf8_stream_converter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import g2u_pkg::*;

    // Run control. The watchdog only counts cycles in which no channel makes a transfer,
    // so it covers the longest search plus long random idle and stall streaks.
    localparam int RESET_CYCLES   = 10;
    localparam int SETTLE_CYCLES  = 48;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int MAX_REPORTS    = 10;
    localparam int DIRECTED_N     = 26;
    localparam int PHASE_N        = 6;
    localparam int SUMMARY_ROW    = 4;

    // Lead bytes that GBK never uses.
    localparam logic [7:0] BAD_LEAD_LO = 8'h80;
    localparam logic [7:0] BAD_LEAD_HI = 8'hFF;

    // One item as it travels on the item channel.
    typedef struct packed {
        logic                   cmd;
        logic [7:0]             text_byte;
        logic [ENTRY_IDX_W-1:0] entry_index;
        logic [CODE_W-1:0]      gbk_code;
        logic [CODE_W-1:0]      unicode;
    } gbk_item_t;

    // One result as it leaves on the result channel.
    typedef struct packed {
        logic [7:0]       out_byte;
        logic             is_summary;
        logic [REG_W-1:0] byte_count;
        logic             last;
    } utf8_result_t;

    // Directed row: the item plus the results read straight off the behavior.
    // n_out is the number of UTF-8 bytes (first byte in the top of utf8), or
    // SUMMARY_ROW for a terminator whose count sits in the low 16 bits.
    typedef struct packed {
        gbk_item_t   item;
        logic [2:0]  n_out;
        logic [23:0] utf8;
    } directed_row_t;

    // Settings of one random phase.
    typedef struct {
        int entries_n;
        int capacity;
        int idle_pct;
        int stall_pct;
        int prefix_n;
        int item_n;
    } phase_t;

    logic clk = 1'b0;
    logic rst_n;

    g2u_item_if   item_ch ();
    g2u_result_if result_ch ();
    g2u_cfg_if    cfg_ch ();

    gbk_to_utf8_stream_converter dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    always #5 clk = ~clk;

    // The directed part loads a five-entry sorted table first: a one-byte, a
    // two-byte and a three-byte code point, a slot mapped to zero, and the largest
    // code point. Then it walks through the byte classes and the special cases.
    directed_row_t directed_rows [DIRECTED_N] = '{
        '{'{CMD_LOAD, 8'h00, 15'd0, 16'h8140, 16'h0041}, 3'd0, 24'h000000},
        '{'{CMD_LOAD, 8'h00, 15'd1, 16'hA1A4, 16'h00B7}, 3'd0, 24'h000000},
        '{'{CMD_LOAD, 8'h00, 15'd2, 16'hB0A1, 16'h554A}, 3'd0, 24'h000000},
        '{'{CMD_LOAD, 8'h00, 15'd3, 16'hD7FA, 16'h0000}, 3'd0, 24'h000000},
        '{'{CMD_LOAD, 8'h00, 15'd4, 16'hFEFE, 16'hFFFF}, 3'd0, 24'h000000},
        // An empty string still gives a summary with a count of zero.
        '{'{CMD_TEXT, TERMINATOR, 15'd0, 16'h0, 16'h0}, 3'd4, 24'h000000},
        // Lowest and highest single-byte characters pass through.
        '{'{CMD_TEXT, 8'h01, 15'd0, 16'h0, 16'h0}, 3'd1, 24'h010000},
        '{'{CMD_TEXT, 8'h7F, 15'd0, 16'h0, 16'h0}, 3'd1, 24'h7F0000},
        // Both invalid lead bytes are dropped silently.
        '{'{CMD_TEXT, BAD_LEAD_LO, 15'd0, 16'h0, 16'h0}, 3'd0, 24'h000000},
        '{'{CMD_TEXT, BAD_LEAD_HI, 15'd0, 16'h0, 16'h0}, 3'd0, 24'h000000},
        // Lowest lead with the lowest trail maps to a single byte.
        '{'{CMD_TEXT, 8'h81, 15'd0, 16'h0, 16'h0}, 3'd0, 24'h000000},
        '{'{CMD_TEXT, 8'h40, 15'd0, 16'h0, 16'h0}, 3'd1, 24'h410000},
        '{'{CMD_TEXT, 8'hA1, 15'd0, 16'h0, 16'h0}, 3'd0, 24'h000000},
        '{'{CMD_TEXT, 8'hA4, 15'd0, 16'h0, 16'h0}, 3'd2, 24'hC2B700},
        '{'{CMD_TEXT, 8'hB0, 15'd0, 16'h0, 16'h0}, 3'd0, 24'h000000},
        '{'{CMD_TEXT, 8'hA1, 15'd0, 16'h0, 16'h0}, 3'd3, 24'hE5958A},
        // Highest lead and trail map to the largest code point.
        '{'{CMD_TEXT, 8'hFE, 15'd0, 16'h0, 16'h0}, 3'd0, 24'h000000},
        '{'{CMD_TEXT, 8'hFE, 15'd0, 16'h0, 16'h0}, 3'd3, 24'hEFBFBF},
        // A table value of zero emits nothing.
        '{'{CMD_TEXT, 8'hD7, 15'd0, 16'h0, 16'h0}, 3'd0, 24'h000000},
        '{'{CMD_TEXT, 8'hFA, 15'd0, 16'h0, 16'h0}, 3'd0, 24'h000000},
        // A trail below 0x40 drops the lead and passes through itself.
        '{'{CMD_TEXT, 8'h81, 15'd0, 16'h0, 16'h0}, 3'd0, 24'h000000},
        '{'{CMD_TEXT, 8'h3F, 15'd0, 16'h0, 16'h0}, 3'd1, 24'h3F0000},
        // A pair that is not in the table emits nothing.
        '{'{CMD_TEXT, 8'h82, 15'd0, 16'h0, 16'h0}, 3'd0, 24'h000000},
        '{'{CMD_TEXT, 8'h41, 15'd0, 16'h0, 16'h0}, 3'd0, 24'h000000},
        // A lead cut off by the terminator is dropped; twelve bytes went out.
        '{'{CMD_TEXT, 8'h90, 15'd0, 16'h0, 16'h0}, 3'd0, 24'h000000},
        '{'{CMD_TEXT, TERMINATOR, 15'd0, 16'h0, 16'h0}, 3'd4, 24'h00000C}
    };

    // Random phases. They reach both extremes of the capacity, run a twelve-entry
    // sorted table and an empty one, and only search slots that were written.
    // Rewrites of the front slots during the strings leave the table unsorted
    // for the later phases, so the search also runs over an unsorted table.
    phase_t phases [PHASE_N] = '{
        '{12, 65535, 0,  0,  12, 28},
        '{0,  256,   57, 0,  0,  12},
        '{12, 256,   57, 0,  12, 20},
        '{12, 3,     0,  57, 0,  18},
        '{12, 0,     34, 34, 0,  12},
        '{12, 40,    34, 34, 0,  24}
    };

    // Model of the table and the string state, kept alongside the block.
    logic [CODE_W-1:0] map_code    [TABLE_DEPTH];
    logic [CODE_W-1:0] map_unicode [TABLE_DEPTH];
    int unsigned       entries_cfg;
    int unsigned       capacity_cfg;
    logic [7:0]        lead_byte;
    logic              lead_held;
    int unsigned       utf8_used;
    logic              utf8_halted;

    utf8_result_t      step_utf8    [$];
    utf8_result_t      typed_utf8   [$];
    utf8_result_t      pending_utf8 [$];
    logic [CODE_W-1:0] prefix_codes [$];

    int sender_idle_pct;
    int receiver_stall_pct;
    int items_accepted;
    int results_checked;
    int mismatch_total;
    int quiet_cycles;
    utf8_result_t seen_utf8;
    utf8_result_t want_utf8;

    // Binary search over the slots in use, exactly as the block walks them:
    // midpoint lo + (hi - lo) / 2, with a miss giving zero.
    function automatic logic [CODE_W-1:0] search_table(input logic [CODE_W-1:0] key);
        int                n;
        int                lo;
        int                hi;
        int                mid;
        logic              found;
        logic [CODE_W-1:0] cp;
        n     = (entries_cfg > TABLE_DEPTH) ? TABLE_DEPTH : int'(entries_cfg);
        lo    = 0;
        hi    = n - 1;
        found = 1'b0;
        cp    = '0;
        while (lo <= hi && !found)
        begin
            mid = lo + (hi - lo) / 2;
            if (map_code[mid] == key)
            begin
                cp    = map_unicode[mid];
                found = 1'b1;
            end
            else if (map_code[mid] < key)
            begin
                lo = mid + 1;
            end
            else
            begin
                hi = mid - 1;
            end
        end
        return cp;
    endfunction

    function automatic void push_utf8(input logic [7:0] data, input logic summ,
                                      input logic [REG_W-1:0] count);
        step_utf8.push_back('{data, summ, count, 1'b0});
    endfunction

    // UTF-8 encoding with the capacity rule: a character that would fill or pass the
    // last byte of the buffer stops output until the terminator.
    function automatic void encode_char(input logic [CODE_W-1:0] cp);
        int unsigned len;
        if (cp == '0 || utf8_halted)
        begin
            return;
        end
        len = (cp < 16'h0080) ? 1 : ((cp < 16'h0800) ? 2 : 3);
        if (utf8_used + len >= capacity_cfg)
        begin
            utf8_halted = 1'b1;
            return;
        end
        if (len == 1)
        begin
            push_utf8(cp[7:0], 1'b0, '0);
        end
        else if (len == 2)
        begin
            push_utf8({3'b110, cp[10:6]}, 1'b0, '0);
            push_utf8({2'b10, cp[5:0]}, 1'b0, '0);
        end
        else
        begin
            push_utf8({4'b1110, cp[15:12]}, 1'b0, '0);
            push_utf8({2'b10, cp[11:6]}, 1'b0, '0);
            push_utf8({2'b10, cp[5:0]}, 1'b0, '0);
        end
        utf8_used += len;
    endfunction

    // Works out the results of one accepted item into step_utf8.
    function automatic void decode_item(input gbk_item_t it);
        logic [7:0] b;
        b = it.text_byte;
        step_utf8.delete();
        if (it.cmd == CMD_LOAD)
        begin
            map_code[it.entry_index]    = it.gbk_code;
            map_unicode[it.entry_index] = it.unicode;
            return;
        end
        if (b == TERMINATOR)
        begin
            push_utf8(8'h00, 1'b1, REG_W'(utf8_used));
            lead_byte   = '0;
            lead_held   = 1'b0;
            utf8_used   = 0;
            utf8_halted = 1'b0;
        end
        else if (lead_held && b >= TRAIL_MIN)
        begin
            lead_held = 1'b0;
            encode_char(search_table({lead_byte, b}));
            lead_byte = '0;
        end
        else
        begin
            lead_held = 1'b0;
            lead_byte = '0;
            if (b < ASCII_LIMIT)
            begin
                encode_char({8'h00, b});
            end
            else if (b >= LEAD_MIN && b <= LEAD_MAX)
            begin
                lead_byte = b;
                lead_held = 1'b1;
            end
        end
        if (step_utf8.size() > 0)
        begin
            step_utf8[step_utf8.size() - 1].last = 1'b1;
        end
    endfunction

    function automatic gbk_item_t text_item(input logic [7:0] b);
        return '{CMD_TEXT, b, '0, '0, '0};
    endfunction

    // Code points from every UTF-8 length, with an occasional zero mapping.
    function automatic logic [CODE_W-1:0] pick_codepoint();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
        begin
            return '0;
        end
        else if (r < 30)
        begin
            return CODE_W'($urandom_range(16'h0001, 16'h007F));
        end
        else if (r < 55)
        begin
            return CODE_W'($urandom_range(16'h0080, 16'h07FF));
        end
        return CODE_W'($urandom_range(16'h0800, 16'hFFFF));
    endfunction

    // Drives one item from a falling edge and holds it until the transfer. The
    // expected results come from the model, or from the typed queue for the
    // directed rows; the model runs in both cases to keep its state in step.
    task automatic send_item(input gbk_item_t it, input logic typed);
        @(negedge clk);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            item_ch.valid <= 1'b0;
            @(negedge clk);
        end
        item_ch.valid          <= 1'b1;
        item_ch.cmd            <= it.cmd;
        item_ch.text_byte      <= it.text_byte;
        item_ch.entry_index    <= it.entry_index;
        item_ch.entry_gbk_code <= it.gbk_code;
        item_ch.entry_unicode  <= it.unicode;
        @(posedge clk);
        while (!item_ch.ready)
        begin
            @(posedge clk);
        end
        decode_item(it);
        if (typed)
        begin
            foreach (typed_utf8[k])
            begin
                pending_utf8.push_back(typed_utf8[k]);
            end
        end
        else
        begin
            foreach (step_utf8[k])
            begin
                pending_utf8.push_back(step_utf8[k]);
            end
        end
        items_accepted++;
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [REG_W-1:0] value);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
        begin
            @(posedge clk);
        end
        if (idx == REG_ENTRIES_IN_USE)
        begin
            entries_cfg = value;
        end
        else
        begin
            capacity_cfg = value;
        end
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Lets the block go idle: all results in, then enough cycles for an item
    // that gives no result to finish its search.
    task automatic settle();
        @(negedge clk);
        item_ch.valid <= 1'b0;
        while (pending_utf8.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes a small sorted table of reachable GBK codes into the front slots.
    task automatic load_prefix(input int count);
        logic [7:0]        lead;
        logic [7:0]        trail;
        logic [CODE_W-1:0] code;
        prefix_codes.delete();
        for (int j = 0; j < count; j++)
        begin
            lead  = 8'(LEAD_MIN + j * 10 + $urandom_range(0, 9));
            trail = 8'($urandom_range(TRAIL_MIN, LEAD_MAX));
            code  = {lead, trail};
            prefix_codes.push_back(code);
            send_item('{CMD_LOAD, 8'h00, ENTRY_IDX_W'(j), code, pick_codepoint()}, 1'b0);
        end
    endtask

    // Random strings: mostly well-formed characters, known pairs among them,
    // mixed with stray pairs, invalid leads, cut-off leads and table rewrites.
    // Every call ends with a terminator so each phase closes its string.
    task automatic run_strings(input int target);
        int                sent;
        int                r;
        logic [CODE_W-1:0] code;
        logic [7:0]        lead;
        logic [14:0]       slot;
        sent = 0;
        while (sent < target)
        begin
            r = $urandom_range(0, 99);
            if (r < 10)
            begin
                send_item(text_item(TERMINATOR), 1'b0);
                sent += 1;
            end
            else if (r < 35)
            begin
                send_item(text_item(8'($urandom_range(1, 8'h7F))), 1'b0);
                sent += 1;
            end
            else if (r < 70)
            begin
                // Most pairs come from the loaded prefix, the rest are mostly misses.
                if (prefix_codes.size() > 0 && $urandom_range(0, 3) != 0)
                begin
                    code = prefix_codes[$urandom_range(0, prefix_codes.size() - 1)];
                end
                else
                begin
                    code = {8'($urandom_range(LEAD_MIN, LEAD_MAX)),
                            7'($urandom_range(8'h20, 8'h7F)), 1'b1};
                end
                send_item(text_item(code[15:8]), 1'b0);
                send_item(text_item(code[7:0]), 1'b0);
                sent += 2;
            end
            else if (r < 80)
            begin
                send_item(text_item(8'($urandom_range(LEAD_MIN, LEAD_MAX))), 1'b0);
                send_item(text_item(8'($urandom_range(0, 255))), 1'b0);
                sent += 2;
            end
            else if (r < 87)
            begin
                lead = ($urandom_range(0, 1) == 1) ? BAD_LEAD_HI : BAD_LEAD_LO;
                send_item(text_item(lead), 1'b0);
                sent += 1;
            end
            else if (r < 92)
            begin
                send_item(text_item(8'($urandom_range(LEAD_MIN, LEAD_MAX))), 1'b0);
                send_item(text_item(TERMINATOR), 1'b0);
                sent += 2;
            end
            else
            begin
                // Rewrites mostly land in the front slots, which unsorts the table.
                slot = ($urandom_range(0, 1) == 1) ? 15'($urandom_range(0, 15))
                                                   : 15'($urandom_range(0, TABLE_DEPTH - 1));
                send_item('{CMD_LOAD, 8'h00, slot, CODE_W'($urandom_range(0, 16'hFFFF)),
                            pick_codepoint()}, 1'b0);
                sent += 1;
            end
        end
        send_item(text_item(TERMINATOR), 1'b0);
    endtask

    // The receiver drops ready at random, changing it only on falling edges.
    always @(negedge clk)
    begin
        result_ch.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end

    // Each result transfer is compared with the oldest expected result.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
        begin
            seen_utf8 = '{result_ch.out_byte, result_ch.is_summary,
                          result_ch.byte_count, result_ch.last};
            results_checked++;
            if (pending_utf8.size() == 0)
            begin
                mismatch_total++;
                if (mismatch_total <= MAX_REPORTS)
                begin
                    $display("Unexpected result: byte %02h summary %0b count %0d last %0b",
                             seen_utf8.out_byte, seen_utf8.is_summary,
                             seen_utf8.byte_count, seen_utf8.last);
                end
            end
            else
            begin
                want_utf8 = pending_utf8.pop_front();
                if (seen_utf8.out_byte !== want_utf8.out_byte ||
                    seen_utf8.is_summary !== want_utf8.is_summary ||
                    seen_utf8.byte_count !== want_utf8.byte_count ||
                    seen_utf8.last !== want_utf8.last)
                begin
                    mismatch_total++;
                    if (mismatch_total <= MAX_REPORTS)
                    begin
                        $display("Mismatch: expected byte %02h summary %0b count %0d last %0b,",
                                 want_utf8.out_byte, want_utf8.is_summary,
                                 want_utf8.byte_count, want_utf8.last);
                        $display("          got      byte %02h summary %0b count %0d last %0b",
                                 seen_utf8.out_byte, seen_utf8.is_summary,
                                 seen_utf8.byte_count, seen_utf8.last);
                    end
                end
            end
        end
    end

    // Watchdog: ends the run after a long stretch without any transfer.
    initial
    begin
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((item_ch.valid === 1'b1 && item_ch.ready === 1'b1) ||
                (result_ch.valid === 1'b1 && result_ch.ready === 1'b1) ||
                (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
        end
        $display("Timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("Verification failed");
        $finish;
    end

    // Main sequence: reset, directed table, random phases.
    initial
    begin
        item_ch.valid          = 1'b0;
        item_ch.cmd            = CMD_TEXT;
        item_ch.text_byte      = '0;
        item_ch.entry_index    = '0;
        item_ch.entry_gbk_code = '0;
        item_ch.entry_unicode  = '0;
        result_ch.ready        = 1'b0;
        cfg_ch.valid           = 1'b0;
        cfg_ch.index           = REG_ENTRIES_IN_USE;
        cfg_ch.data            = '0;
        rst_n                  = 1'b0;

        // The model starts from the reset values of the registers and the string state.
        entries_cfg        = 0;
        capacity_cfg       = CAPACITY_RESET;
        lead_byte          = '0;
        lead_held          = 1'b0;
        utf8_used          = 0;
        utf8_halted        = 1'b0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        items_accepted     = 0;
        results_checked    = 0;
        mismatch_total     = 0;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // The directed rows search only the five slots they load first.
        write_register(REG_ENTRIES_IN_USE, REG_W'(5));
        foreach (directed_rows[r])
        begin
            typed_utf8.delete();
            if (directed_rows[r].n_out == SUMMARY_ROW)
            begin
                typed_utf8.push_back('{8'h00, 1'b1, directed_rows[r].utf8[15:0], 1'b1});
            end
            else
            begin
                for (int k = 0; k < directed_rows[r].n_out; k++)
                begin
                    typed_utf8.push_back('{directed_rows[r].utf8[23 - 8 * k -: 8], 1'b0,
                                           16'h0000, (k == directed_rows[r].n_out - 1)});
                end
            end
            send_item(directed_rows[r].item, 1'b1);
        end
        settle();

        foreach (phases[p])
        begin
            write_register(REG_ENTRIES_IN_USE, REG_W'(phases[p].entries_n));
            write_register(REG_OUTPUT_CAPACITY, REG_W'(phases[p].capacity));
            sender_idle_pct    = phases[p].idle_pct;
            receiver_stall_pct = phases[p].stall_pct;
            if (phases[p].prefix_n > 0)
            begin
                load_prefix(phases[p].prefix_n);
            end
            run_strings(phases[p].item_n);
            settle();
        end

        $display("Covered %0d directed rows and %0d random phases with idle and stall mixes.",
                 DIRECTED_N, PHASE_N);
        $display("Accepted %0d items, checked %0d results, %0d mismatches, %0d missing.",
                 items_accepted, results_checked, mismatch_total, pending_utf8.size());
        if (mismatch_total == 0 && pending_utf8.size() == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/g2u_pkg.sv
rtl/g2u_ifs.sv
rtl/g2u_table.sv
rtl/g2u_search.sv
rtl/gbk_to_utf8_stream_converter.sv
dv/gbk_to_utf8_stream_converter_tb.sv
